/* rtl/fea_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fea_pkg;

	// Flow fixed point and frame limits
	localparam int FRAC_BITS    = 6;
	localparam int MAX_PIXELS   = 2097152;
	localparam int CORDIC_STEPS = 24;
	localparam int PI_HALF      = 26353589;
	localparam int ANGLE_MAX    = 51472;

	localparam logic signed [15:0] OCCL_RESET = 16'sh7FFF;
	localparam logic [21:0]        MAX_COUNT  = 22'(MAX_PIXELS);
	localparam logic [15:0]        ANGLE_MAX_Q = 16'(ANGLE_MAX);

	// Arctangent of 2^-i in units of 2^-24 rad
	typedef logic [24:0] atan_t;
	localparam atan_t ATAN_TABLE [CORDIC_STEPS] = '{
		25'd13176795, 25'd7778716, 25'd4110060, 25'd2086331,
		25'd1047214,  25'd524117,  25'd262123,  25'd131069,
		25'd65536,    25'd32768,   25'd16384,   25'd8192,
		25'd4096,     25'd2048,    25'd1024,    25'd512,
		25'd256,      25'd128,     25'd64,      25'd32,
		25'd16,       25'd8,       25'd4,       25'd2
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SQRT,
		ST_CINIT,
		ST_CORDIC,
		ST_ACC,
		ST_FIN,
		ST_DIV,
		ST_OUT
	} fea_state_t;

endpackage
`default_nettype wire

/* rtl/flow_error_accumulator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Flow error accumulator: compares an estimated with a reference flow vector per pixel and
// sums angular, L1 and L2 endpoint errors over masked pixels; on the last pixel it returns the
// rounded means, the masked count and an empty flag, then clears its sums. Pixels are taken one
// at a time. A masked pixel passes through the shared 33x33 multiplier, a bit-pair square root
// for the cross product length and 24 CORDIC iterations, and, when its endpoint errors count,
// 19 more square root steps for the L2 error. The last pixel adds three 39-step divisions, skipped
// when the frame is empty. A result waits in its output register; the next frame result is held
// until that one is taken.
module flow_error_accumulator (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_wr_en,
	input  wire signed [15:0] cfg_wr_data,
	input  wire               pix_valid,
	output logic              pix_ready,
	input  wire signed [15:0] est_dx,
	input  wire signed [15:0] est_dy,
	input  wire signed [15:0] ref_dx,
	input  wire signed [15:0] ref_dy,
	input  wire               in_mask,
	input  wire               last_pixel,
	output logic              res_valid,
	input  wire               res_ready,
	output logic [15:0]       mean_angle,
	output logic [16:0]       mean_l1,
	output logic [16:0]       mean_l2,
	output logic [21:0]       pixel_count,
	output logic              empty_frame
);
	import fea_pkg::*;

	fea_state_t state_q, state_d;

	logic signed [15:0] occl_q;
	logic signed [15:0] ex_q, ey_q, rx_q, ry_q;
	logic signed [16:0] dex_q, dey_q;
	logic               occl_ok_q, last_q;

	logic [36:0] angle_sum_q;
	logic [37:0] l1_sum_q, l2_sum_q;
	logic [21:0] count_q;

	logic [3:0]         k_q;
	logic signed [32:0] mul_a, mul_b, c1_w, c2_w;
	logic signed [65:0] prod_q;
	logic signed [33:0] d_q;
	logic signed [32:0] c3_q;
	logic [63:0]        csq_q;
	logic [34:0]        l2sq_q;

	logic [63:0] sq_n_q, sq_res_q, sq_bit_q, sq_sum;
	logic        sq_l2_q, sq_take;

	logic signed [35:0] x_q, y_q, xs, ys;
	logic signed [27:0] z_q, zsum;
	logic signed [17:0] zr;
	logic [4:0]         i_q;
	logic [15:0]        angle_w;

	logic [38:0] div_num_q, div_quo_q, div_init;
	logic [21:0] div_rem_q;
	logic [22:0] div_shift, div_diff;
	logic        div_bit;
	logic [5:0]  div_cnt_q;
	logic [1:0]  div_sel_q;
	logic [38:0] div_quo_n;

	logic [15:0] st_angle_q;
	logic [16:0] st_l1_q, st_l2_q;
	logic        st_empty_q;

	logic [16:0] adx, ady;
	logic [17:0] l1_add;
	logic [18:0] l2_add;

	logic pix_acc, go, out_free;

	assign pix_acc  = pix_valid && pix_ready;
	assign go       = in_mask && (count_q < MAX_COUNT);
	assign out_free = !res_valid || res_ready;

	// Select multiplier operands per sequencer step
	assign c1_w = 33'(dey_q) <<< FRAC_BITS;
	assign c2_w = 33'(dex_q) <<< FRAC_BITS;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (k_q)
			4'd0: begin mul_a = 33'(ex_q); mul_b = 33'(rx_q); end
			4'd1: begin mul_a = 33'(ey_q); mul_b = 33'(ry_q); end
			4'd2: begin mul_a = 33'(ex_q); mul_b = 33'(ry_q); end
			4'd3: begin mul_a = 33'(ey_q); mul_b = 33'(rx_q); end
			4'd4: begin mul_a = c1_w; mul_b = c1_w; end
			4'd5: begin mul_a = c2_w; mul_b = c2_w; end
			4'd6: begin mul_a = c3_q; mul_b = c3_q; end
			4'd7: begin mul_a = 33'(dex_q); mul_b = 33'(dex_q); end
			4'd8: begin mul_a = 33'(dey_q); mul_b = 33'(dey_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// Square root step, one bit pair per cycle
	assign sq_sum  = sq_res_q + sq_bit_q;
	assign sq_take = sq_n_q >= sq_sum;

	// CORDIC shifts and angle rounding
	assign xs   = x_q >>> i_q;
	assign ys   = y_q >>> i_q;
	assign zsum = z_q + 28'sd512;
	assign zr   = zsum[27:10];

	always_comb begin
		if (zr < 18'sd0) begin
			angle_w = '0;
		end else if (zr > $signed({2'b00, ANGLE_MAX_Q})) begin
			angle_w = ANGLE_MAX_Q;
		end else begin
			angle_w = zr[15:0];
		end
	end

	// Endpoint error terms
	assign adx    = dex_q[16] ? 17'(-dex_q) : 17'(dex_q);
	assign ady    = dey_q[16] ? 17'(-dey_q) : 17'(dey_q);
	assign l1_add = 18'(adx) + 18'(ady);
	assign l2_add = 19'(({1'b0, sq_res_q[17:0]} + 19'd1) >> 1);

	// Divider step and numerator of the next division
	assign div_shift = {div_rem_q, div_num_q[38]};
	assign div_diff  = div_shift - {1'b0, count_q};
	assign div_bit   = div_shift >= {1'b0, count_q};
	assign div_quo_n = {div_quo_q[37:0], div_bit};

	always_comb begin
		case (div_sel_q)
			2'd0:    div_init = 39'(l1_sum_q) + 39'(count_q >> 1);
			default: div_init = 39'(l2_sum_q) + 39'(count_q >> 1);
		endcase
	end

	// Hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance sequencer
	always_comb begin
		state_d   = state_q;
		pix_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pix_ready = 1'b1;
				if (pix_valid) begin
					if (go) begin
						state_d = ST_MUL;
					end else if (last_pixel) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_MUL:    if (k_q == 4'd9) state_d = ST_SQRT;
			ST_SQRT: begin
				if (sq_bit_q[0]) state_d = sq_l2_q ? ST_ACC : ST_CINIT;
			end
			ST_CINIT:  state_d = ST_CORDIC;
			ST_CORDIC: begin
				if (i_q == 5'(CORDIC_STEPS - 1)) state_d = occl_ok_q ? ST_SQRT : ST_ACC;
			end
			ST_ACC:    state_d = last_q ? ST_FIN : ST_IDLE;
			ST_FIN:    state_d = (count_q == '0) ? ST_OUT : ST_DIV;
			ST_DIV:    if (div_cnt_q == 6'd38 && div_sel_q == 2'd2) state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occl_q <= OCCL_RESET;
		end else if (cfg_wr_en) begin
			occl_q <= cfg_wr_data;
		end
	end

	// Accumulators and output transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_sum_q <= '0;
			l1_sum_q    <= '0;
			l2_sum_q    <= '0;
			count_q     <= '0;
			res_valid   <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				res_valid <= 1'b1;
			end else if (res_valid && res_ready) begin
				res_valid <= 1'b0;
			end
			if (state_q == ST_ACC) begin
				count_q     <= count_q + 22'd1;
				angle_sum_q <= angle_sum_q + 37'(angle_w);
				if (occl_ok_q) begin
					l1_sum_q <= l1_sum_q + 38'(l1_add);
					l2_sum_q <= l2_sum_q + 38'(l2_add);
				end
			end
			if (state_q == ST_OUT && out_free) begin
				angle_sum_q <= '0;
				l1_sum_q    <= '0;
				l2_sum_q    <= '0;
				count_q     <= '0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			mean_angle  <= st_angle_q;
			mean_l1     <= st_l1_q;
			mean_l2     <= st_l2_q;
			pixel_count <= count_q;
			empty_frame <= st_empty_q;
		end
	end

	// Datapath: capture, multiply, square root, CORDIC, divide
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pix_acc) begin
					ex_q      <= est_dx;
					ey_q      <= est_dy;
					rx_q      <= ref_dx;
					ry_q      <= ref_dy;
					dex_q     <= 17'(est_dx) - 17'(ref_dx);
					dey_q     <= 17'(est_dy) - 17'(ref_dy);
					occl_ok_q <= (ref_dx < occl_q) || (ref_dy < occl_q);
					last_q    <= last_pixel;
					k_q       <= '0;
					d_q       <= 34'sd1 <<< (2 * FRAC_BITS);
					c3_q      <= '0;
					csq_q     <= '0;
					l2sq_q    <= '0;
				end
			end
			ST_MUL: begin
				prod_q <= mul_a * mul_b;
				k_q    <= k_q + 4'd1;
				case (k_q)
					4'd1, 4'd2:       d_q    <= d_q + $signed(prod_q[33:0]);
					4'd3:             c3_q   <= c3_q + $signed(prod_q[32:0]);
					4'd4:             c3_q   <= c3_q - $signed(prod_q[32:0]);
					4'd5, 4'd6, 4'd7: csq_q  <= csq_q + prod_q[63:0];
					4'd8, 4'd9:       l2sq_q <= l2sq_q + prod_q[34:0];
					default:          ;
				endcase
				if (k_q == 4'd9) begin
					sq_n_q   <= csq_q;
					sq_res_q <= '0;
					sq_bit_q <= 64'd1 << 62;
					sq_l2_q  <= 1'b0;
				end
			end
			ST_SQRT: begin
				sq_bit_q <= sq_bit_q >> 2;
				if (sq_take) begin
					sq_n_q   <= sq_n_q - sq_sum;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
			end
			ST_CINIT: begin
				i_q <= '0;
				if (d_q < 34'sd0) begin
					x_q <= $signed({4'b0000, sq_res_q[31:0]});
					y_q <= 36'(-d_q);
					z_q <= 28'(PI_HALF);
				end else begin
					x_q <= 36'(d_q);
					y_q <= $signed({4'b0000, sq_res_q[31:0]});
					z_q <= '0;
				end
			end
			ST_CORDIC: begin
				i_q <= i_q + 5'd1;
				if (y_q > 36'sd0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + $signed({3'b000, ATAN_TABLE[i_q]});
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - $signed({3'b000, ATAN_TABLE[i_q]});
				end
				if (i_q == 5'(CORDIC_STEPS - 1)) begin
					sq_n_q   <= 64'(l2sq_q) << 2;
					sq_res_q <= '0;
					sq_bit_q <= 64'd1 << 36;
					sq_l2_q  <= 1'b1;
				end
			end
			ST_FIN: begin
				st_empty_q <= (count_q == '0);
				st_angle_q <= '0;
				st_l1_q    <= '0;
				st_l2_q    <= '0;
				div_sel_q  <= '0;
				div_cnt_q  <= '0;
				div_rem_q  <= '0;
				div_num_q  <= 39'(angle_sum_q) + 39'(count_q >> 1);
			end
			ST_DIV: begin
				div_quo_q <= div_quo_n;
				if (div_cnt_q == 6'd38) begin
					// Store the quotient and load the next numerator
					case (div_sel_q)
						2'd0:    st_angle_q <= div_quo_n[15:0];
						2'd1:    st_l1_q    <= div_quo_n[16:0];
						default: st_l2_q    <= div_quo_n[16:0];
					endcase
					div_sel_q <= div_sel_q + 2'd1;
					div_cnt_q <= '0;
					div_rem_q <= '0;
					div_num_q <= div_init;
				end else begin
					div_num_q <= div_num_q << 1;
					div_rem_q <= div_bit ? div_diff[21:0] : div_shift[21:0];
					div_cnt_q <= div_cnt_q + 6'd1;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/fea_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module fea_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        res_valid,
	input wire        res_ready,
	input wire [15:0] mean_angle,
	input wire [16:0] mean_l1,
	input wire [16:0] mean_l2,
	input wire [21:0] pixel_count,
	input wire        empty_frame
);
	import fea_pkg::*;

	// Hold a stalled result transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(pixel_count))
		else $error("result count changed while stalled");

	// Empty frame gives zero means and count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && empty_frame |->
		mean_angle == 16'd0 && mean_l1 == 17'd0 && mean_l2 == 17'd0 && pixel_count == 22'd0)
		else $error("empty frame with nonzero fields");

	// Non-empty frame has a count in range
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !empty_frame |-> pixel_count != 22'd0 && pixel_count <= MAX_COUNT)
		else $error("bad pixel count");

	// Mean angle stays within pi
	a_angle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> mean_angle <= ANGLE_MAX_Q)
		else $error("mean angle out of range");

endmodule

bind flow_error_accumulator fea_checker u_fea_checker (.*);
`default_nettype wire
